// File: hw/rtl/qlc_pkg.sv
// ----------------------------------------------------------------------------
// qlc_pkg
// Shared types, constants and defaults for the Q-learning corridor block.
// ----------------------------------------------------------------------------
package qlc_pkg;

    localparam int QLC_MAX_CELLS = 64;
    localparam int QLC_Q_WIDTH   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int NS_REG_W   = 7;
    localparam int RATE_W     = 17;
    localparam int EPI_W      = 16;
    localparam int DRAW_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int POS_OUT_W  = 6;
    localparam int Q_OUT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_N_STATES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EPISODES = 3'd4;

    localparam logic [NS_REG_W-1:0] RST_N_STATES     = 7'd6;
    localparam logic [RATE_W-1:0]   RST_EPSILON      = 17'd58982;
    localparam logic [RATE_W-1:0]   RST_ALPHA        = 17'd6554;
    localparam logic [RATE_W-1:0]   RST_GAMMA        = 17'd58982;
    localparam logic [EPI_W-1:0]    RST_MAX_EPISODES = 16'd13;

    localparam logic [EPI_W-1:0] EPI_SAT = 16'hFFFF;
    localparam int MIN_STATES = 3;
    localparam int ROUND_HALF = 32768;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW_S,
        S_ROW_N,
        S_MAG,
        S_WRITE,
        S_FIN
    } t_state;

endpackage

// File: hw/rtl/qlc_ram.sv
// ----------------------------------------------------------------------------
// qlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/tabular_q_learning_corridor.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_corridor
// One tabular Q-learning step per item on a corridor with left/right actions,
// or a finished result once learning has stopped.
// After reset the block sweeps all MAX_CELLS rows (64 by default) of the Q
// RAM to zero, one row per cycle, and stalls input meanwhile; configuration
// writes are taken at any time. A learning step reads the current row as the
// item is accepted, then the next row in S_ROW_S, does a registered gamma
// multiply in S_ROW_N and a registered alpha multiply in S_MAG, and writes
// back and loads its result in S_WRITE. The next item is taken only back in
// S_IDLE, after the result is loaded, so items do not overlap; S_WRITE waits
// while the output is stalled. A step after learning has finished loads its
// result in S_FIN. The Q table keeps one row per cell holding both action
// values, in a RAM with one read and one write port. The result register lets
// the next item be accepted while a result still waits; the write-back waits
// until that register is free.
// ----------------------------------------------------------------------------
module tabular_q_learning_corridor
    import qlc_pkg::*;
#(
    parameter int MAX_CELLS = QLC_MAX_CELLS,
    parameter int Q_WIDTH   = QLC_Q_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DRAW_W-1:0]     i_rnd_explore,
    input  logic                  i_rnd_action,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_chosen_action,
    output logic [POS_OUT_W-1:0]  o_position,
    output logic [POS_OUT_W-1:0]  o_next_position,
    output logic                  o_reward,
    output logic [Q_OUT_W-1:0]    o_q_updated,
    output logic                  o_episode_end,
    output logic [EPI_W-1:0]      o_episode_number,
    output logic                  o_finished
);

    localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int NS_W   = (CELL_W + 1 > NS_REG_W) ? CELL_W + 1 : NS_REG_W;
    localparam int ROW_W  = 2 * Q_WIDTH;
    localparam int T_W    = Q_WIDTH + 1;
    localparam int PROD_W = Q_WIDTH + RATE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = Q_WIDTH + 2;
    localparam int POS_W  = (CELL_W > POS_OUT_W) ? CELL_W : POS_OUT_W;
    localparam int OQ_W   = (Q_WIDTH > Q_OUT_W) ? Q_WIDTH : Q_OUT_W;

    localparam logic [Q_WIDTH-1:0] Q_ONE    = {1'b1, {(Q_WIDTH-1){1'b0}}};
    localparam logic [CELL_W-1:0]  LAST_ROW = CELL_W'(MAX_CELLS - 1);
    localparam logic [NS_W-1:0]    NS_MIN   = NS_W'(MIN_STATES);
    localparam logic [NS_W-1:0]    NS_MAX   = NS_W'(MAX_CELLS);
    localparam logic [SUM_W-1:0]   RND      = SUM_W'(ROUND_HALF);

    t_state r_state, n_state;

    // configuration
    logic [NS_REG_W-1:0] r_n_states;
    logic [RATE_W-1:0]   r_epsilon, r_alpha, r_gamma;
    logic [EPI_W-1:0]    r_max_episodes;

    // episode state
    logic [CELL_W-1:0] r_cell;
    logic [EPI_W-1:0]  r_count;
    logic              r_pending, r_done;
    logic [CELL_W-1:0] r_clr;

    // step datapath
    logic [DRAW_W-1:0]  r_draw;
    logic               r_ract;
    logic [Q_WIDTH-1:0] r_q0, r_q1, r_pred;
    logic [T_W-1:0]     r_target;
    logic               r_act, r_term, r_up;
    logic [CELL_W-1:0]  r_nxt;
    logic [MAG_W-1:0]   r_mag;

    // result register
    logic                 r_out_valid;
    logic                 r_out_act, r_out_rew, r_out_fin;
    logic [POS_OUT_W-1:0] r_out_pos, r_out_nxt;
    logic [Q_OUT_W-1:0]   r_out_q;
    logic [EPI_W-1:0]     r_out_epi;

    // control
    logic              in_acc, out_free, start, hit_limit, done_next;
    logic              ram_we, load_step, load_fin;
    logic [CELL_W-1:0] ram_waddr, ram_raddr, cell0;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;

    // combinational datapath
    logic [Q_WIDTH-1:0] rd_q0, rd_q1, mx, pred_c, qnew;
    logic [T_W-1:0]     diff;
    logic               explore, act_c, term_c;
    logic [CELL_W-1:0]  nxt_c;
    logic [NS_W-1:0]    ns_ext, ns_lim;
    logic [PROD_W-1:0]  prod_g, prod_a;
    logic [SUM_W-1:0]   sum_g, sum_a;
    logic [MAG_W:0]     inc;
    logic [POS_W-1:0]   pos_ext, nxt_ext;
    logic [OQ_W-1:0]    q_ext;

    qlc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CELLS)
    ) u_qram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_acc    = i_in_valid && !o_in_stall;
    assign start     = !r_done && r_pending;
    assign hit_limit = r_count >= r_max_episodes;
    assign done_next = r_done || (start && hit_limit);
    assign cell0     = start ? '0 : r_cell;

    // current row: policy and move
    assign rd_q0   = ram_rdata[Q_WIDTH-1:0];
    assign rd_q1   = ram_rdata[ROW_W-1:Q_WIDTH];
    assign explore = ({1'b0, r_draw} > r_epsilon) || (rd_q0 == '0 && rd_q1 == '0);
    assign act_c   = explore ? r_ract : (rd_q0 < rd_q1);
    assign pred_c  = act_c ? rd_q1 : rd_q0;
    assign ns_ext  = NS_W'(r_n_states);

    always_comb begin
        priority if (ns_ext < NS_MIN) begin
            ns_lim = NS_MIN;
        end else if (ns_ext > NS_MAX) begin
            ns_lim = NS_MAX;
        end else begin
            ns_lim = ns_ext;
        end
    end

    always_comb begin
        term_c = 1'b0;
        if (act_c) begin
            nxt_c  = (r_cell == LAST_ROW) ? r_cell : r_cell + 1'b1;
            term_c = NS_W'(r_cell) >= ns_lim - NS_W'(2);
        end else begin
            nxt_c = (r_cell == '0) ? '0 : r_cell - 1'b1;
        end
    end

    // next row: discounted target
    assign mx     = (rd_q0 >= rd_q1) ? rd_q0 : rd_q1;
    assign prod_g = PROD_W'(r_gamma) * PROD_W'(mx);
    assign sum_g  = SUM_W'(prod_g) + RND;

    // alpha step
    assign diff   = r_up ? r_target - T_W'(r_pred) : T_W'(r_pred) - r_target;
    assign prod_a = PROD_W'(diff) * PROD_W'(r_alpha);
    assign sum_a  = SUM_W'(prod_a) + RND;

    always_comb begin
        inc = (MAG_W + 1)'(r_pred) + (MAG_W + 1)'(r_mag);
        if (r_up) begin
            qnew = (inc > (MAG_W + 1)'(Q_ONE)) ? Q_ONE : inc[Q_WIDTH-1:0];
        end else begin
            qnew = (r_mag >= MAG_W'(r_pred)) ? '0 : r_pred - r_mag[Q_WIDTH-1:0];
        end
    end

    assign pos_ext = POS_W'(r_cell);
    assign nxt_ext = POS_W'(r_nxt);
    assign q_ext   = OQ_W'(qnew);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_ROW) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = done_next ? S_FIN : S_ROW_S;
            end
            S_ROW_S: n_state = S_ROW_N;
            S_ROW_N: n_state = S_MAG;
            S_MAG:   n_state = S_WRITE;
            S_WRITE: begin
                if (out_free) n_state = S_IDLE;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = r_cell;
        ram_wdata  = '0;
        ram_raddr  = r_cell;
        load_step  = 1'b0;
        load_fin   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                ram_raddr  = cell0;
            end
            S_ROW_S: ram_raddr = nxt_c;
            S_ROW_N, S_MAG: ;
            S_WRITE: begin
                ram_we    = out_free;
                load_step = out_free;
                ram_wdata = r_act ? {qnew, r_q0} : {r_q1, qnew};
            end
            S_FIN: load_fin = out_free;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_n_states     <= RST_N_STATES;
            r_epsilon      <= RST_EPSILON;
            r_alpha        <= RST_ALPHA;
            r_gamma        <= RST_GAMMA;
            r_max_episodes <= RST_MAX_EPISODES;
            r_cell         <= '0;
            r_count        <= '0;
            r_pending      <= 1'b1;
            r_done         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_N_STATES:     r_n_states     <= i_cfg_data[NS_REG_W-1:0];
                    REG_EPSILON:      r_epsilon      <= i_cfg_data;
                    REG_ALPHA:        r_alpha        <= i_cfg_data;
                    REG_GAMMA:        r_gamma        <= i_cfg_data;
                    REG_MAX_EPISODES: r_max_episodes <= i_cfg_data[EPI_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && start) begin
                r_pending <= 1'b0;
                r_cell    <= '0;
                if (hit_limit) begin
                    r_done <= 1'b1;
                end else if (r_count != EPI_SAT) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (load_step) begin
                r_cell <= r_nxt;
                if (r_term) r_pending <= 1'b1;
            end
            if (load_step || load_fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_draw <= i_rnd_explore;
            r_ract <= i_rnd_action;
        end
        if (r_state == S_ROW_S) begin
            r_q0   <= rd_q0;
            r_q1   <= rd_q1;
            r_act  <= act_c;
            r_pred <= pred_c;
            r_nxt  <= nxt_c;
            r_term <= term_c;
        end
        if (r_state == S_ROW_N) begin
            r_target <= r_term ? T_W'(Q_ONE) : sum_g[FRAC_W +: T_W];
            r_up     <= r_term ? (Q_ONE >= r_pred) :
                                 (sum_g[FRAC_W +: T_W] >= T_W'(r_pred));
        end
        if (r_state == S_MAG) begin
            r_mag <= sum_a[FRAC_W +: MAG_W];
        end
        if (load_step) begin
            r_out_act <= r_act;
            r_out_pos <= pos_ext[POS_OUT_W-1:0];
            r_out_nxt <= nxt_ext[POS_OUT_W-1:0];
            r_out_rew <= r_term;
            r_out_q   <= q_ext[Q_OUT_W-1:0];
            r_out_epi <= r_count;
            r_out_fin <= 1'b0;
        end else if (load_fin) begin
            r_out_act <= 1'b0;
            r_out_pos <= pos_ext[POS_OUT_W-1:0];
            r_out_nxt <= pos_ext[POS_OUT_W-1:0];
            r_out_rew <= 1'b0;
            r_out_q   <= '0;
            r_out_epi <= r_count;
            r_out_fin <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chosen_action  = r_out_act;
    assign o_position       = r_out_pos;
    assign o_next_position  = r_out_nxt;
    assign o_reward         = r_out_rew;
    assign o_q_updated      = r_out_q;
    assign o_episode_end    = r_out_rew;
    assign o_episode_number = r_out_epi;
    assign o_finished       = r_out_fin;

endmodule

// File: tb/tabular_q_learning_corridor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabular_q_learning_corridor_tb
// Self-checking bench for the Q-learning corridor block. A short directed
// table covers reset behavior, the walls, the terminal step, clamped corridor
// sizes and the rate extremes. Random learning steps follow under several
// register settings and three idling mixes. A built-in model of the learning
// step predicts every item, and each result is compared field by field in
// order. The last phase lowers the episode limit so that learning stops.
// ----------------------------------------------------------------------------
module tabular_q_learning_corridor_tb;
    import qlc_pkg::*;

    localparam int Q_ONE        = 1 << (QLC_Q_WIDTH - 1);
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 150;
    localparam int N_PHASES     = 6;
    localparam int N_DIR        = 36;

    typedef struct packed {
        logic                 act;
        logic [POS_OUT_W-1:0] pos;
        logic [POS_OUT_W-1:0] nxt;
        logic                 rew;
        logic [Q_OUT_W-1:0]   q;
        logic                 ep_end;
        logic [EPI_W-1:0]     epi;
        logic                 fin;
    } t_step_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [DRAW_W-1:0]      draw;
        logic                   ract;
        logic                   typed;
        t_step_res              want;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 0, 1, '{0, 0, 0, 0, 0, 0, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 1, '{1, 0, 1, 0, 0, 0, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h8000, 1, 1, '{1, 1, 2, 0, 0, 0, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 1, '{1, 2, 3, 0, 0, 0, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 1, '{1, 3, 4, 0, 0, 0, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h1234, 1, 1, '{1, 4, 5, 1, 3277, 1, 1, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 0, 1, '{0, 0, 0, 0, 0, 0, 2, 0}},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 1, '{1, 0, 1, 0, 0, 0, 2, 0}},
        '{ROW_CFG, REG_MAX_EPISODES, 65535, 0, 0, 0, '0},
        '{ROW_CFG, REG_ALPHA, 65536, 0, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h7FFF, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'd58982, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'd58983, 0, 0, '0},
        '{ROW_CFG, REG_N_STATES, 0, 0, 0, 0, '0},
        '{ROW_CFG, REG_EPSILON, 0, 0, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0001, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 0, '0},
        '{ROW_CFG, REG_N_STATES, 127, 0, 0, 0, '0},
        '{ROW_CFG, REG_GAMMA, 131071, 0, 0, 0, '0},
        '{ROW_CFG, REG_ALPHA, 131071, 0, 0, 0, '0},
        '{ROW_CFG, REG_EPSILON, 65536, 0, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 0, '0},
        '{ROW_CFG, REG_N_STATES, 3, 0, 0, 0, '0},
        '{ROW_CFG, REG_EPSILON, 0, 0, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0},
        '{ROW_CFG, REG_GAMMA, 0, 0, 0, 0, '0},
        '{ROW_CFG, REG_ALPHA, 0, 0, 0, 0, '0},
        '{ROW_CFG, REG_EPSILON, 131071, 0, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 1, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'h0000, 0, 0, '0},
        '{ROW_ITEM, REG_N_STATES, 0, 16'hFFFF, 1, 0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [DRAW_W-1:0]     i_rnd_explore;
    logic                  i_rnd_action;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_chosen_action;
    logic [POS_OUT_W-1:0]  o_position;
    logic [POS_OUT_W-1:0]  o_next_position;
    logic                  o_reward;
    logic [Q_OUT_W-1:0]    o_q_updated;
    logic                  o_episode_end;
    logic [EPI_W-1:0]      o_episode_number;
    logic                  o_finished;

    // learning state mirrored from the block
    logic [Q_OUT_W-1:0]  q_tab [2*QLC_MAX_CELLS];
    int                  agent_cell;
    logic [EPI_W-1:0]    epi_count;
    logic                epi_pending;
    logic                learn_done;
    logic [NS_REG_W-1:0] cfg_cells;
    logic [RATE_W-1:0]   cfg_epsilon;
    logic [RATE_W-1:0]   cfg_alpha;
    logic [RATE_W-1:0]   cfg_gamma;
    logic [EPI_W-1:0]    cfg_max_epi;

    t_step_res expected_steps [$];
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    tabular_q_learning_corridor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rnd_explore    (i_rnd_explore),
        .i_rnd_action     (i_rnd_action),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chosen_action  (o_chosen_action),
        .o_position       (o_position),
        .o_next_position  (o_next_position),
        .o_reward         (o_reward),
        .o_q_updated      (o_q_updated),
        .o_episode_end    (o_episode_end),
        .o_episode_number (o_episode_number),
        .o_finished       (o_finished)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_step_res learn_step(logic [DRAW_W-1:0] draw, logic ract);
        t_step_res   r;
        int          ns;
        int          s;
        int          nx;
        logic        act;
        logic        term;
        logic [39:0] q0, q1, pred, target, mx, mag, inc, qn, a0, a1;
        r  = '0;
        ns = cfg_cells;
        if (ns < MIN_STATES) ns = MIN_STATES;
        if (ns > QLC_MAX_CELLS) ns = QLC_MAX_CELLS;
        if (!learn_done && epi_pending) begin
            epi_pending = 1'b0;
            agent_cell  = 0;
            if (epi_count >= cfg_max_epi) begin
                learn_done = 1'b1;
            end else if (epi_count != EPI_SAT) begin
                epi_count = epi_count + 1'b1;
            end
        end
        if (learn_done) begin
            r.pos = agent_cell[POS_OUT_W-1:0];
            r.nxt = agent_cell[POS_OUT_W-1:0];
            r.epi = epi_count;
            r.fin = 1'b1;
            return r;
        end
        s  = agent_cell;
        q0 = q_tab[2*s];
        q1 = q_tab[2*s+1];
        if ({1'b0, draw} > cfg_epsilon || (q0 == 0 && q1 == 0)) begin
            act = ract;
        end else begin
            act = (q0 >= q1) ? 1'b0 : 1'b1;
        end
        term = 1'b0;
        if (act) begin
            nx = s + 1;
            if (s >= ns - 2) term = 1'b1;
        end else begin
            nx = (s == 0) ? 0 : s - 1;
        end
        if (nx >= QLC_MAX_CELLS) nx = QLC_MAX_CELLS - 1;
        pred = q_tab[2*s+act];
        if (term) begin
            target = Q_ONE;
        end else begin
            a0     = q_tab[2*nx];
            a1     = q_tab[2*nx+1];
            mx     = (a0 >= a1) ? a0 : a1;
            target = (cfg_gamma * mx + ROUND_HALF) >> FRAC_W;
        end
        if (target >= pred) begin
            mag = ((target - pred) * cfg_alpha + ROUND_HALF) >> FRAC_W;
            inc = pred + mag;
            qn  = (inc > Q_ONE) ? Q_ONE : inc;
        end else begin
            mag = ((pred - target) * cfg_alpha + ROUND_HALF) >> FRAC_W;
            qn  = (mag >= pred) ? 0 : pred - mag;
        end
        q_tab[2*s+act] = qn[Q_OUT_W-1:0];
        agent_cell     = nx;
        if (term) epi_pending = 1'b1;
        r.act    = act;
        r.pos    = s[POS_OUT_W-1:0];
        r.nxt    = nx[POS_OUT_W-1:0];
        r.rew    = term;
        r.q      = qn[Q_OUT_W-1:0];
        r.ep_end = term;
        r.epi    = epi_count;
        r.fin    = 1'b0;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        case ($urandom_range(0, 3))
            0, 1: return DRAW_W'($urandom_range(0, 65535));
            2: return DRAW_W'($urandom_range(0, 4095));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return cfg_epsilon[DRAW_W-1:0];
                    default: return cfg_epsilon[DRAW_W-1:0] + 1'b1;
                endcase
            end
        endcase
    endfunction

    function automatic logic pick_action();
        return $urandom_range(0, 9) < 7;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return RATE_W'(0);
            1: return RATE_W'(65536);
            2: return RATE_W'(131071);
            default: return RATE_W'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_N_STATES:     cfg_cells   = val[NS_REG_W-1:0];
            REG_EPSILON:      cfg_epsilon = val[RATE_W-1:0];
            REG_ALPHA:        cfg_alpha   = val[RATE_W-1:0];
            REG_GAMMA:        cfg_gamma   = val[RATE_W-1:0];
            REG_MAX_EPISODES: cfg_max_epi = val[EPI_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic [DRAW_W-1:0] draw, logic ract, logic typed, t_step_res want);
        t_step_res pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_rnd_explore <= draw;
        i_rnd_action  <= ract;
        do @(posedge i_clk); while (o_in_stall);
        pred = learn_step(draw, ract);
        if (typed) pred = want;
        expected_steps = {expected_steps, pred};
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase_config(logic finishing);
        logic [CFG_DATA_W-1:0] ns_v, eps_v, me_v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: ns_v = CFG_DATA_W'($urandom_range(3, 8));
            6: ns_v = CFG_DATA_W'($urandom_range(0, 2));
            7: ns_v = $urandom_range(0, 1) ? CFG_DATA_W'(64) : CFG_DATA_W'(127);
            default: ns_v = CFG_DATA_W'($urandom_range(9, 24));
        endcase
        case ($urandom_range(0, 7))
            0: eps_v = CFG_DATA_W'(0);
            1: eps_v = CFG_DATA_W'(65536);
            2: eps_v = CFG_DATA_W'(131071);
            default: eps_v = CFG_DATA_W'($urandom_range(32768, 65536));
        endcase
        me_v = $urandom_range(0, 1) ? CFG_DATA_W'(65535) :
               CFG_DATA_W'($urandom_range(int'(epi_count) + 200, 65535));
        if (finishing) begin
            ns_v  = CFG_DATA_W'(3);
            eps_v = CFG_DATA_W'(0);
            me_v  = CFG_DATA_W'(0);
        end
        cfg_write(REG_N_STATES, ns_v);
        cfg_write(REG_EPSILON, eps_v);
        cfg_write(REG_ALPHA, pick_rate());
        cfg_write(REG_GAMMA, pick_rate());
        cfg_write(REG_MAX_EPISODES, me_v);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_step_res w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_steps.size() == 0) begin
                $error("result with no item pending");
                error_count++;
            end else begin
                w = expected_steps.pop_front();
                check_field("chosen_action", w.act, o_chosen_action);
                check_field("position", w.pos, o_position);
                check_field("next_position", w.nxt, o_next_position);
                check_field("reward", w.rew, o_reward);
                check_field("q_updated", w.q, o_q_updated);
                check_field("episode_end", w.ep_end, o_episode_end);
                check_field("episode_number", w.epi, o_episode_number);
                check_field("finished", w.fin, o_finished);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        int fin_seen;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_N_STATES;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_rnd_explore = '0;
        i_rnd_action  = 1'b0;
        i_out_stall   = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 11;
        recv_idle_pct = 62;
        foreach (q_tab[i]) q_tab[i] = '0;
        agent_cell  = 0;
        epi_count   = '0;
        epi_pending = 1'b1;
        learn_done  = 1'b0;
        cfg_cells   = RST_N_STATES;
        cfg_epsilon = RST_EPSILON;
        cfg_alpha   = RST_ALPHA;
        cfg_gamma   = RST_GAMMA;
        cfg_max_epi = RST_MAX_EPISODES;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (DIR_TAB[k].kind == ROW_CFG) begin
                wait_drained();
                cfg_write(DIR_TAB[k].idx, DIR_TAB[k].data);
            end else begin
                send_item(DIR_TAB[k].draw, DIR_TAB[k].ract, DIR_TAB[k].typed,
                          DIR_TAB[k].want);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 62;
            end else if (ph < 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            set_phase_config(1'b0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold off until the block has drained once per phase
                if (k == PHASE_ITEMS / 2) wait_drained();
                send_item(pick_draw(), pick_action(), 1'b0, '0);
            end
        end

        // drop the episode limit so learning stops at the next episode start
        wait_drained();
        set_phase_config(1'b1);
        k        = 0;
        fin_seen = 0;
        while (fin_seen < 30 && k < 4000) begin
            send_item(pick_draw(), pick_action(), 1'b0, '0);
            if (learn_done) fin_seen++;
            k++;
        end

        wait_drained();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/qlc_pkg.sv
hw/rtl/qlc_ram.sv
hw/rtl/tabular_q_learning_corridor.sv
tb/tabular_q_learning_corridor_tb.sv
